[rtl/core/psft_pkg.sv]
// Shared constants, types and helpers of the publish/subscribe fan-out table.
`default_nettype none
package psft_pkg;

  // Table geometry.
  localparam int TOPICS = 128;
  localparam int SLOTS  = 16;

  // Field widths of the channels.
  localparam int TOPIC_W   = 7;
  localparam int ID_W      = 8;
  localparam int PAYLOAD_W = 32;
  localparam int KIND_W    = 2;

  // Derived widths and depths.
  localparam int TOPIC_AW  = (TOPICS > 1) ? $clog2(TOPICS) : 1;
  localparam int SLOT_AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int IDS_DEPTH = TOPICS * (2 ** SLOT_AW);

  // Depth of the queue between the front and the back part.
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Operation codes of an input beat.
  localparam logic OP_PUBLISH   = 1'b0;
  localparam logic OP_SUBSCRIBE = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_FORWARD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OK      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd2;

  // Sender id carried by subscribe replies.
  localparam logic [ID_W-1:0] REPLY_FROM = 8'd1;

  // Classified command handed from the front to the back part.
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [TOPIC_W-1:0]   topic;
    logic [ID_W-1:0]      sender;
    logic [PAYLOAD_W-1:0] payload;
    logic [CNT_W-1:0]     cnt;
  } cmd_t;

  // Write port of the subscriber id store.
  typedef struct packed {
    logic                         we;
    logic [TOPIC_AW+SLOT_AW-1:0]  addr;
    logic [ID_W-1:0]              data;
  } ids_wr_t;

  // Row address of a topic in the tables.
  function automatic logic [TOPIC_AW-1:0] topic_addr(input logic [TOPIC_W-1:0] t);
    return TOPIC_AW'(t);
  endfunction

endpackage
`default_nettype wire

[rtl/core/psft_if.sv]
// Channel interfaces of the publish/subscribe fan-out table.
`default_nettype none
interface psft_in_if;
  import psft_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [TOPIC_W-1:0]   topic;
  logic [ID_W-1:0]      sender_id;
  logic [PAYLOAD_W-1:0] payload;

  modport source (output valid, output opcode, output topic, output sender_id,
                  output payload, input ready);
  modport sink   (input valid, input opcode, input topic, input sender_id,
                  input payload, output ready);
endinterface

interface psft_out_if;
  import psft_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    reply_kind;
  logic [ID_W-1:0]      receiver_id;
  logic [ID_W-1:0]      from_id;
  logic [TOPIC_W-1:0]   out_topic;
  logic [PAYLOAD_W-1:0] out_payload;
  logic                 last;

  modport source (output valid, output reply_kind, output receiver_id, output from_id,
                  output out_topic, output out_payload, output last, input ready);
  modport sink   (input valid, input reply_kind, input receiver_id, input from_id,
                  input out_topic, input out_payload, input last, output ready);
endinterface
`default_nettype wire

[rtl/core/psft_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module psft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/psft_front.sv]
// Front part: accepts beats, looks up the topic's subscriber count and classifies.
`default_nettype none
module psft_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  psft_in_if.sink              in_ch,
  output      logic            push_vld,
  output      psft_pkg::cmd_t  push_cmd,
  input  wire logic            push_rdy,
  output      psft_pkg::ids_wr_t ids_wr
);
  import psft_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic                 state_r, state_nxt;
  logic                 item_op_r;
  logic [TOPIC_W-1:0]   item_topic_r;
  logic [ID_W-1:0]      item_sender_r;
  logic [PAYLOAD_W-1:0] item_payload_r;

  logic [TOPICS-1:0]    cnt_vld_r;
  logic                 cnt_vld_q_r;
  logic [TOPIC_AW-1:0]  cnt_raddr;
  logic [TOPIC_AW-1:0]  item_row;
  logic [CNT_W-1:0]     cnt_q;
  logic [CNT_W-1:0]     cur_cnt;
  logic                 in_table;
  logic                 need_push;
  logic                 room;
  logic                 sub_wr;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign item_row    = topic_addr(item_topic_r);

  // The count lookup follows the input while idle and holds on the item afterwards.
  assign cnt_raddr = (state_r == ST_IDLE) ? topic_addr(in_ch.topic) : item_row;

  psft_ram #(
    .WIDTH(CNT_W),
    .DEPTH(TOPICS)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (sub_wr),
    .waddr(item_row),
    .wdata(CNT_W'(cur_cnt + 1'b1)),
    .raddr(cnt_raddr),
    .rdata(cnt_q)
  );

  // A count row that was never written reads as zero.
  assign in_table = (int'(item_topic_r) < TOPICS);
  assign cur_cnt  = cnt_vld_q_r ? cnt_q : '0;
  assign room     = (cur_cnt < CNT_W'(SLOTS));

  // Classify the held item into a command for the back part.
  always_comb begin
    push_cmd.topic   = item_topic_r;
    push_cmd.sender  = item_sender_r;
    push_cmd.payload = item_payload_r;
    push_cmd.cnt     = cur_cnt;
    if (item_op_r == OP_SUBSCRIBE) begin
      push_cmd.kind = (in_table && room) ? KIND_OK : KIND_FULL;
      need_push     = 1'b1;
    end else begin
      push_cmd.kind = KIND_FORWARD;
      need_push     = in_table && (cur_cnt != '0);
    end
  end

  assign push_vld = (state_r == ST_LOOK) && need_push;
  assign sub_wr   = push_vld && push_rdy && (push_cmd.kind == KIND_OK);

  // Append the sender to the topic's list when the subscribe is taken.
  assign ids_wr.we   = sub_wr;
  assign ids_wr.addr = {item_row, SLOT_AW'(cur_cnt)};
  assign ids_wr.data = item_sender_r;

  // Sequencing: idle, then a lookup state that waits for queue room if needed.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!need_push || push_rdy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (sub_wr) begin
        cnt_vld_r[item_row] <= 1'b1;
      end
    end
  end

  // The valid bit is read alongside the count RAM.
  always_ff @(posedge clk) begin
    cnt_vld_q_r <= cnt_vld_r[cnt_raddr];
  end

  // Capture the accepted beat.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_op_r      <= in_ch.opcode;
      item_topic_r   <= in_ch.topic;
      item_sender_r  <= in_ch.sender_id;
      item_payload_r <= in_ch.payload;
    end
  end

endmodule
`default_nettype wire

[rtl/core/psft_queue.sv]
// Short command queue between the front and the back part.
`default_nettype none
module psft_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_vld,
  input  wire psft_pkg::cmd_t push_cmd,
  output      logic           push_rdy,
  output      logic           pop_vld,
  output      psft_pkg::cmd_t pop_cmd,
  input  wire logic           pop_rdy
);
  import psft_pkg::*;

  cmd_t              entries_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r, fill_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_rdy = (fill_r != QCNT_W'(QDEPTH));
  assign pop_vld  = (fill_r != '0);
  assign pop_cmd  = entries_r[rd_ptr_r];
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop_vld && pop_rdy;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = do_push ? QAW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? QAW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = QCNT_W'(fill_r + 1'b1);
    end else if (do_pop && !do_push) begin
      fill_nxt = QCNT_W'(fill_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

[rtl/core/psft_back.sv]
// Back part: turns commands into replies or into one forwarded copy per subscriber.
`default_nettype none
module psft_back (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  pop_vld,
  input  wire psft_pkg::cmd_t                        pop_cmd,
  output      logic                                  pop_rdy,
  output      logic [psft_pkg::TOPIC_AW+psft_pkg::SLOT_AW-1:0] ids_raddr,
  input  wire logic [psft_pkg::ID_W-1:0]             ids_rdata,
  psft_out_if.source                                 out_ch
);
  import psft_pkg::*;

  localparam logic [1:0] BK_IDLE  = 2'd0;
  localparam logic [1:0] BK_REPLY = 2'd1;
  localparam logic [1:0] BK_FAN   = 2'd2;

  logic [1:0]           state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [SLOT_AW-1:0]   idx_r, idx_nxt;
  logic                 is_last;
  logic                 can_ld;
  logic                 load;

  logic                 out_vld_r, out_vld_nxt;
  logic [KIND_W-1:0]    ld_kind,    out_kind_r;
  logic [ID_W-1:0]      ld_recv,    out_recv_r;
  logic [ID_W-1:0]      ld_from,    out_from_r;
  logic [TOPIC_W-1:0]   ld_topic,   out_topic_r;
  logic [PAYLOAD_W-1:0] ld_payload, out_payload_r;
  logic                 ld_last,    out_last_r;

  assign can_ld  = !out_vld_r || out_ch.ready;
  assign is_last = ((CNT_W'(idx_r) + CNT_W'(1)) == cmd_r.cnt);

  // The id read follows the next slot index, so read data always matches idx_r.
  assign ids_raddr = {topic_addr(cmd_nxt.topic), idx_nxt};

  // Command sequencing and output loading.
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    pop_rdy    = 1'b0;
    load       = 1'b0;
    ld_kind    = cmd_r.kind;
    ld_recv    = cmd_r.sender;
    ld_from    = REPLY_FROM;
    ld_topic   = cmd_r.topic;
    ld_payload = '0;
    ld_last    = 1'b1;
    unique case (state_r)
      BK_IDLE: begin
        pop_rdy = 1'b1;
        if (pop_vld) begin
          cmd_nxt   = pop_cmd;
          idx_nxt   = '0;
          state_nxt = (pop_cmd.kind == KIND_FORWARD) ? BK_FAN : BK_REPLY;
        end
      end
      BK_REPLY: begin
        if (can_ld) begin
          load      = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      BK_FAN: begin
        ld_recv    = ids_rdata;
        ld_from    = cmd_r.sender;
        ld_payload = cmd_r.payload;
        ld_last    = is_last;
        if (can_ld) begin
          load = 1'b1;
          if (is_last) begin
            state_nxt = BK_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Output register parts the back part from the receiver.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    if (load) begin
      out_kind_r    <= ld_kind;
      out_recv_r    <= ld_recv;
      out_from_r    <= ld_from;
      out_topic_r   <= ld_topic;
      out_payload_r <= ld_payload;
      out_last_r    <= ld_last;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.reply_kind  = out_kind_r;
  assign out_ch.receiver_id = out_recv_r;
  assign out_ch.from_id     = out_from_r;
  assign out_ch.out_topic   = out_topic_r;
  assign out_ch.out_payload = out_payload_r;
  assign out_ch.last        = out_last_r;

endmodule
`default_nettype wire

[rtl/core/publish_subscribe_fanout_table.sv]
// Top level of the publish/subscribe fan-out table.
//
// The in_ch channel takes one beat per item: a subscribe adds the sender to the
// topic's list, a publish sends its payload to every subscriber of the topic.
// The out_ch channel gives results: one ok or full reply per subscribe, one
// forwarded copy per subscriber for a publish (last marks the final copy), and
// nothing for a publish to an empty topic. Both use valid/ready handshakes.
// The front accepts an item, reads the topic's count RAM and classifies it, and
// in_ch takes no new beat until that item has been classified. A two-entry
// command queue lets the front keep accepting while the back part works.
// The back part emits one reply per subscribe command; for a publish it emits
// one copy per cycle from the subscriber id RAM while the receiver is ready.
// When the receiver stalls, the output register holds its beat and the back
// part and then the queue fill up before in_ch drops ready.
// Synchronous active-low reset clears the subscriber counts at once through a
// valid bit per topic; no clearing pass runs and in_ch is ready after reset.
`default_nettype none
module publish_subscribe_fanout_table (
  input  wire logic  clk,
  input  wire logic  rst_n,
  psft_in_if.sink    in_ch,
  psft_out_if.source out_ch
);
  import psft_pkg::*;

  logic                          push_vld;
  logic                          push_rdy;
  cmd_t                          push_cmd;
  logic                          pop_vld;
  logic                          pop_rdy;
  cmd_t                          pop_cmd;
  ids_wr_t                       ids_wr;
  logic [TOPIC_AW+SLOT_AW-1:0]   ids_raddr;
  logic [ID_W-1:0]               ids_rdata;

  // Lookup and classification.
  psft_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .push_vld(push_vld),
    .push_cmd(push_cmd),
    .push_rdy(push_rdy),
    .ids_wr  (ids_wr)
  );

  // Command queue.
  psft_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_vld(push_vld),
    .push_cmd(push_cmd),
    .push_rdy(push_rdy),
    .pop_vld (pop_vld),
    .pop_cmd (pop_cmd),
    .pop_rdy (pop_rdy)
  );

  // Subscriber id store, one row of slots per topic.
  psft_ram #(
    .WIDTH(ID_W),
    .DEPTH(IDS_DEPTH)
  ) u_ids_ram (
    .clk  (clk),
    .we   (ids_wr.we),
    .waddr(ids_wr.addr),
    .wdata(ids_wr.data),
    .raddr(ids_raddr),
    .rdata(ids_rdata)
  );

  // Reply and fan-out generation.
  psft_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_vld  (pop_vld),
    .pop_cmd  (pop_cmd),
    .pop_rdy  (pop_rdy),
    .ids_raddr(ids_raddr),
    .ids_rdata(ids_rdata),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

[rtl/core/psft_checker.sv]
// Port-level checks of the fan-out table and their bind to the top level.
`default_nettype none
module psft_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [psft_pkg::KIND_W-1:0]     out_reply_kind,
  input wire logic [psft_pkg::ID_W-1:0]       out_receiver_id,
  input wire logic [psft_pkg::ID_W-1:0]       out_from_id,
  input wire logic [psft_pkg::TOPIC_W-1:0]    out_topic,
  input wire logic [psft_pkg::PAYLOAD_W-1:0]  out_payload,
  input wire logic                            out_last
);
  import psft_pkg::*;

  // A stalled result beat keeps its kind, receiver, payload and last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reply_kind) &&
      $stable(out_receiver_id) && $stable(out_payload) && $stable(out_last))
    else $error("result beat changed while stalled");

  // A subscribe reply is always the only result of its item.
  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_reply_kind != KIND_FORWARD) |-> out_last)
    else $error("subscribe reply without last");

  // Replies carry the fixed sender id and an empty payload.
  a_reply_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_reply_kind != KIND_FORWARD) |->
      (out_from_id == REPLY_FROM) && (out_payload == '0))
    else $error("subscribe reply with wrong sender or payload");

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // Topic is only checked for being driven alongside a valid beat.
  a_topic_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_topic))
    else $error("result topic unknown");

endmodule

bind publish_subscribe_fanout_table psft_checker u_psft_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_reply_kind (out_ch.reply_kind),
  .out_receiver_id(out_ch.receiver_id),
  .out_from_id    (out_ch.from_id),
  .out_topic      (out_ch.out_topic),
  .out_payload    (out_ch.out_payload),
  .out_last       (out_ch.last)
);
`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the publish/subscribe fan-out table.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psft_pkg::*;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int STALL_LIMIT = 3000;
  // Cycles to wait after the last expected beat, for late extra beats.
  localparam int DRAIN_CYCLES = 24;
  localparam int SHOWN_ERRORS = 10;

  // One result beat of the out channel.
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [ID_W-1:0]      receiver;
    logic [ID_W-1:0]      src_id;
    logic [TOPIC_W-1:0]   topic;
    logic [PAYLOAD_W-1:0] payload;
    logic                 last;
  } fanout_beat_t;

  logic clk;
  logic rst_n;

  psft_in_if  in_ch ();
  psft_out_if out_ch ();

  publish_subscribe_fanout_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the subscriber table.
  logic [CNT_W-1:0] sub_count [TOPICS];
  logic [ID_W-1:0]  sub_list  [TOPICS][SLOTS];

  fanout_beat_t pending_beats [$];

  int in_idle_pct;
  int out_stall_pct;
  int error_count;
  int quiet_cycles;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Known values on every input from time zero.
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_PUBLISH;
    in_ch.topic      = '0;
    in_ch.sender_id  = '0;
    in_ch.payload    = '0;
    out_ch.ready     = 1'b0;
    in_idle_pct      = 0;
    out_stall_pct    = 0;
    error_count      = 0;
    quiet_cycles     = 0;
    for (int t = 0; t < TOPICS; t++) begin
      sub_count[t] = '0;
    end
  end

  // Computes the beats one accepted item causes and updates the shadow table.
  task automatic predict_fanout(input logic op, input logic [TOPIC_W-1:0] topic,
                                input logic [ID_W-1:0] sender,
                                input logic [PAYLOAD_W-1:0] body);
    fanout_beat_t beat;
    int n;
    if (op == OP_SUBSCRIBE) begin
      beat.kind     = KIND_FULL;
      beat.receiver = sender;
      beat.src_id   = REPLY_FROM;
      beat.topic    = topic;
      beat.payload  = '0;
      beat.last     = 1'b1;
      if (int'(sub_count[topic]) < SLOTS) begin
        sub_list[topic][sub_count[topic]] = sender;
        sub_count[topic] = sub_count[topic] + 1'b1;
        beat.kind = KIND_OK;
      end
      pending_beats.push_back(beat);
    end else begin
      n = int'(sub_count[topic]);
      for (int i = 0; i < n; i++) begin
        beat.kind     = KIND_FORWARD;
        beat.receiver = sub_list[topic][i];
        beat.src_id   = sender;
        beat.topic    = topic;
        beat.payload  = body;
        beat.last     = (i == n - 1);
        pending_beats.push_back(beat);
      end
    end
  endtask

  // Sends one item; valid stays high afterwards unless the next item idles first.
  task automatic send_item(input logic op, input logic [TOPIC_W-1:0] topic,
                           input logic [ID_W-1:0] sender,
                           input logic [PAYLOAD_W-1:0] body);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.topic     <= topic;
    in_ch.sender_id <= sender;
    in_ch.payload   <= body;
    do @(posedge clk); while (!in_ch.ready);
    predict_fanout(op, topic, sender, body);
  endtask

  // A publish to a topic nobody has joined gives no beat at all.
  task automatic test_empty_publish();
    send_item(OP_PUBLISH, 7'd42, 8'd9, 32'h1234_5678);
  endtask

  // The same id listed twice gets two copies; publish payload and all ids at zero.
  task automatic test_repeat_subscribe();
    send_item(OP_SUBSCRIBE, 7'd0, 8'd0, 32'hFFFF_FFFF);
    send_item(OP_SUBSCRIBE, 7'd0, 8'd0, 32'h0);
    send_item(OP_PUBLISH, 7'd0, 8'd0, 32'h0);
  endtask

  // Fill the highest topic, overflow it once, then publish the widest fan-out.
  task automatic test_full_list();
    for (int i = 0; i < SLOTS; i++) begin
      send_item(OP_SUBSCRIBE, 7'd127, 8'(i * 17), $urandom);
    end
    send_item(OP_SUBSCRIBE, 7'd127, 8'd200, 32'hA5A5_5A5A);
    send_item(OP_PUBLISH, 7'd127, 8'd255, 32'hFFFF_FFFF);
  endtask

  // Random traffic: mostly a few busy topics so lists fill and fan out wide.
  task automatic test_random_traffic(input int items, input int idle_pct,
                                     input int stall_pct);
    logic [TOPIC_W-1:0] topic;
    logic op;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(99) < 70) begin
        topic = 7'($urandom_range(15));
      end else begin
        topic = 7'($urandom_range(TOPICS - 1));
      end
      op = ($urandom_range(99) < 50) ? OP_SUBSCRIBE : OP_PUBLISH;
      send_item(op, topic, 8'($urandom), $urandom);
    end
  endtask

  // Receiver ready pattern.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    fanout_beat_t seen;
    fanout_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.kind     = out_ch.reply_kind;
      seen.receiver = out_ch.receiver_id;
      seen.src_id   = out_ch.from_id;
      seen.topic    = out_ch.out_topic;
      seen.payload  = out_ch.out_payload;
      seen.last     = out_ch.last;
      if (pending_beats.size() == 0) begin
        error_count++;
        if (error_count <= SHOWN_ERRORS) begin
          $display("unexpected beat: kind %0d recv %0d from %0d topic %0d data %h last %0b",
                   seen.kind, seen.receiver, seen.src_id, seen.topic, seen.payload,
                   seen.last);
        end
      end else begin
        want = pending_beats.pop_front();
        if (seen.kind !== want.kind || seen.receiver !== want.receiver ||
            seen.src_id !== want.src_id || seen.topic !== want.topic ||
            seen.payload !== want.payload || seen.last !== want.last) begin
          error_count++;
          if (error_count <= SHOWN_ERRORS) begin
            $display("mismatch exp: kind %0d recv %0d from %0d topic %0d data %h last %0b",
                     want.kind, want.receiver, want.src_id, want.topic, want.payload,
                     want.last);
            $display("         got: kind %0d recv %0d from %0d topic %0d data %h last %0b",
                     seen.kind, seen.receiver, seen.src_id, seen.topic, seen.payload,
                     seen.last);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_publish();
    test_repeat_subscribe();
    test_full_list();

    test_random_traffic(52, 0, 0);
    test_random_traffic(52, 86, 0);
    test_random_traffic(52, 0, 86);
    test_random_traffic(52, 21, 21);

    in_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
